// ----- rtl/core/twodm_pkg.sv -----
package twodm_pkg;

   localparam int NUM_WHEELS = 3;
   localparam int WHEEL_ANGLE [NUM_WHEELS] = '{150, 30, 270};

   localparam int FULL_TURN     = 360;
   localparam int HALF_TURN     = 180;
   localparam int QUARTER_TURN  = 90;
   localparam int THREE_QUARTER = 270;
   // keeps wheel - heading positive for any 10-bit heading
   localparam int ANGLE_BIAS    = 720;

   localparam int HEADING_W = 10;
   localparam int SPEED_W   = 9;
   localparam int DUTY_W    = 8;
   localparam int ANG_W     = 11;   // biased angle, below 2048
   localparam int RED_W     = 9;    // angle mod 360
   localparam int FOLD_W    = 7;    // folded angle 0..90
   localparam int VAL_W     = 11;   // signed wheel value, +-512
   localparam int MAG_W     = 10;   // wheel magnitude, up to 512
   localparam int NUM_W     = 17;   // magnitude * limit

   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEP    = 2;  // quotient bits per divider stage
   localparam int DIV_FIRST   = 5;  // pipe index of first divider stage
   localparam int PIPE_STAGES = DIV_FIRST + DIV_STAGES;

   localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 8'd100;

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam int TAYLOR_TERMS = 12;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   // cosine magnitude of r degrees (0..90), rounded to frac_bits fraction bits
   function automatic longint unsigned cos_q_mag(input int r, input int frac_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint signed   sum;
      longint unsigned c;
      x    = (64'(r) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum  = 64'sd1 <<< 30;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if ((n % 2) == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      c = (longint'(unsigned'(sum)) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
      return c;
   endfunction

endpackage

// ----- rtl/core/three_wheel_omni_drive_mixer.sv -----
// Throughput: one word per cycle; a full stage holds while the next one stalls.
// Stages: angle fold, cosine table, speed multiply, correction and magnitude,
// max and rescale multiply, then four stages of a 2-bit-per-stage divider.
// Reset: clears all stage valids; duty_limit returns to 100.
module three_wheel_omni_drive_mixer import twodm_pkg::*; #(
   parameter int COS_FRAC_BITS = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [HEADING_W-1:0] req_heading_deg,
   input  logic signed [SPEED_W-1:0]   req_speed,
   input  logic signed [SPEED_W-1:0]   req_correction,
   input  logic                        req_turn_right,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [DUTY_W-1:0]           rsp_wheel_a_duty,
   output logic [DUTY_W-1:0]           rsp_wheel_b_duty,
   output logic [DUTY_W-1:0]           rsp_wheel_c_duty,
   output logic                        rsp_wheel_a_fwd,
   output logic                        rsp_wheel_b_fwd,
   output logic                        rsp_wheel_c_fwd,
   input  logic                        csr_wr_en,
   input  logic [DUTY_W-1:0]           csr_wr_data
);

   localparam int CW     = COS_FRAC_BITS + 1;
   localparam int PROD_W = CW + SPEED_W;

   logic [DUTY_W-1:0]      duty_limit_ff;
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] en;

   // stage 1
   logic [FOLD_W-1:0]         fold_in  [NUM_WHEELS];
   logic                      cneg_in  [NUM_WHEELS];
   logic [FOLD_W-1:0]         fold_ff  [NUM_WHEELS];
   logic                      cneg_ff  [NUM_WHEELS];
   logic [SPEED_W-1:0]        sabs_in;
   logic [SPEED_W-1:0]        sabs1_ff;
   logic                      sneg1_ff;
   logic signed [SPEED_W-1:0] corr1_ff;
   logic                      right1_ff;
   // stage 2
   logic [CW-1:0]             cmag_in  [NUM_WHEELS];
   logic [CW-1:0]             cmag_ff  [NUM_WHEELS];
   logic                      sign2_ff [NUM_WHEELS];
   logic [SPEED_W-1:0]        sabs2_ff;
   logic signed [SPEED_W-1:0] corr2_ff;
   logic                      right2_ff;
   // stage 3
   logic [PROD_W-1:0]         prod_ff  [NUM_WHEELS];
   logic                      sign3_ff [NUM_WHEELS];
   logic signed [SPEED_W-1:0] corr3_ff;
   logic                      right3_ff;
   // stage 4
   logic [MAG_W-1:0]          mag_in   [NUM_WHEELS];
   logic                      fwd_in   [NUM_WHEELS];
   logic [MAG_W-1:0]          mag_ff   [NUM_WHEELS];
   // direction bits, from stage 4 to the output
   logic                      fwd_ff   [DIV_STAGES+2][NUM_WHEELS];
   // stage 5
   logic [NUM_W-1:0]          num_in   [NUM_WHEELS];
   logic [MAG_W-1:0]          den_in;
   logic [NUM_W-1:0]          num_ff   [NUM_WHEELS];
   logic [MAG_W-1:0]          den_ff;
   logic [DUTY_W-1:0]         duty     [NUM_WHEELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_limit_ff <= DUTY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         duty_limit_ff <= csr_wr_data;
      end
   end

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: wheel angle minus heading, mod 360, folded into the first quadrant
   always_comb begin
      logic [ANG_W-1:0] raw;
      logic [RED_W-1:0] ang;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         raw = ANG_W'(WHEEL_ANGLE[w] + ANGLE_BIAS) - ANG_W'(req_heading_deg);
         if (raw >= ANG_W'(4 * FULL_TURN)) begin
            ang = RED_W'(raw - ANG_W'(4 * FULL_TURN));
         end else if (raw >= ANG_W'(3 * FULL_TURN)) begin
            ang = RED_W'(raw - ANG_W'(3 * FULL_TURN));
         end else if (raw >= ANG_W'(2 * FULL_TURN)) begin
            ang = RED_W'(raw - ANG_W'(2 * FULL_TURN));
         end else if (raw >= ANG_W'(FULL_TURN)) begin
            ang = RED_W'(raw - ANG_W'(FULL_TURN));
         end else begin
            ang = RED_W'(raw);
         end
         if (ang <= RED_W'(QUARTER_TURN)) begin
            fold_in[w] = FOLD_W'(ang);
            cneg_in[w] = 1'b0;
         end else if (ang <= RED_W'(HALF_TURN)) begin
            fold_in[w] = FOLD_W'(RED_W'(HALF_TURN) - ang);
            cneg_in[w] = 1'b1;
         end else if (ang <= RED_W'(THREE_QUARTER)) begin
            fold_in[w] = FOLD_W'(ang - RED_W'(HALF_TURN));
            cneg_in[w] = 1'b1;
         end else begin
            fold_in[w] = FOLD_W'(RED_W'(FULL_TURN) - ang);
            cneg_in[w] = 1'b0;
         end
      end
      sabs_in = req_speed[SPEED_W-1] ? SPEED_W'(-req_speed) : SPEED_W'(req_speed);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         fold_ff   <= fold_in;
         cneg_ff   <= cneg_in;
         sabs1_ff  <= sabs_in;
         sneg1_ff  <= req_speed[SPEED_W-1];
         corr1_ff  <= req_correction;
         right1_ff <= req_turn_right;
      end
   end

   // stage 2: cosine magnitude
   for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_cos
      twodm_cos_lut #(
         .COS_FRAC_BITS(COS_FRAC_BITS)
      ) u_cos_lut (
         .fold    (fold_ff[w]),
         .cos_mag (cmag_in[w])
      );
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cmag_ff   <= cmag_in;
         for (int w = 0; w < NUM_WHEELS; w++) begin
            sign2_ff[w] <= cneg_ff[w] ^ sneg1_ff;
         end
         sabs2_ff  <= sabs1_ff;
         corr2_ff  <= corr1_ff;
         right2_ff <= right1_ff;
      end
   end

   // stage 3: |cos| * |speed|
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int w = 0; w < NUM_WHEELS; w++) begin
            prod_ff[w] <= PROD_W'(cmag_ff[w]) * PROD_W'(sabs2_ff);
         end
         sign3_ff  <= sign2_ff;
         corr3_ff  <= corr2_ff;
         right3_ff <= right2_ff;
      end
   end

   // stage 4: truncate toward zero, apply correction, split into sign and magnitude
   always_comb begin
      logic signed [VAL_W-1:0] v;
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] sum;
      cx = VAL_W'(corr3_ff);
      for (int w = 0; w < NUM_WHEELS; w++) begin
         v = VAL_W'({1'b0, prod_ff[w][PROD_W-1:COS_FRAC_BITS]});
         if (sign3_ff[w]) begin
            v = -v;
         end
         sum       = right3_ff ? v + cx : v - cx;
         fwd_in[w] = !sum[VAL_W-1];
         mag_in[w] = sum[VAL_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         mag_ff    <= mag_in;
      end
   end

   // stage 5: largest magnitude picks the divisor; unscaled words divide by one
   always_comb begin
      logic [MAG_W-1:0] max_mag;
      logic             scale;
      max_mag = mag_ff[0];
      for (int w = 1; w < NUM_WHEELS; w++) begin
         if (mag_ff[w] > max_mag) begin
            max_mag = mag_ff[w];
         end
      end
      scale = max_mag > MAG_W'(duty_limit_ff);
      for (int w = 0; w < NUM_WHEELS; w++) begin
         num_in[w] = scale ? NUM_W'(mag_ff[w]) * NUM_W'(duty_limit_ff)
                           : NUM_W'(mag_ff[w]);
      end
      den_in = scale ? max_mag : MAG_W'(1);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         num_ff    <= num_in;
         den_ff    <= den_in;
      end
   end

   // stages 6..9: division
   for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_div
      twodm_divider u_divider (
         .clock    (clock),
         .stage_en (en[DIV_FIRST +: DIV_STAGES]),
         .num      (num_ff[w]),
         .den      (den_ff),
         .quo      (duty[w])
      );
   end

   // direction bits ride along from stage 4 to the output
   always_ff @(posedge clock) begin
      if (en[3]) begin
         fwd_ff[0] <= fwd_in;
      end
      if (en[4]) begin
         fwd_ff[1] <= fwd_ff[0];
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (en[DIV_FIRST + j]) begin
            fwd_ff[j+2] <= fwd_ff[j+1];
         end
      end
   end

   assign rsp_wheel_a_duty = duty[0];
   assign rsp_wheel_b_duty = duty[1];
   assign rsp_wheel_c_duty = duty[2];
   assign rsp_wheel_a_fwd  = fwd_ff[DIV_STAGES+1][0];
   assign rsp_wheel_b_fwd  = fwd_ff[DIV_STAGES+1][1];
   assign rsp_wheel_c_fwd  = fwd_ff[DIV_STAGES+1][2];

endmodule

// ----- rtl/core/twodm_cos_lut.sv -----
module twodm_cos_lut import twodm_pkg::*; #(
   parameter int COS_FRAC_BITS = 15
) (
   input  logic [FOLD_W-1:0]      fold,
   output logic [COS_FRAC_BITS:0] cos_mag
);

   localparam int CW = COS_FRAC_BITS + 1;

   logic [CW-1:0] cos_rom [QUARTER_TURN+1];

   for (genvar g = 0; g <= QUARTER_TURN; g++) begin : g_rom
      assign cos_rom[g] = CW'(cos_q_mag(g, COS_FRAC_BITS));
   end

   always_comb begin
      if (fold <= FOLD_W'(QUARTER_TURN)) begin
         cos_mag = cos_rom[fold];
      end else begin
         cos_mag = '0;
      end
   end

endmodule

// ----- rtl/core/twodm_divider.sv -----
// restoring divider, DIV_STEP quotient bits per stage; needs num < 2^DUTY_W * den
module twodm_divider import twodm_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [NUM_W-1:0]      num,
   input  logic [MAG_W-1:0]      den,
   output logic [DUTY_W-1:0]     quo
);

   logic [NUM_W-1:0]  rem_ff [DIV_STAGES-1];
   logic [MAG_W-1:0]  den_ff [DIV_STAGES-1];
   logic [DUTY_W-1:0] quo_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [NUM_W-1:0]  rem_src;
      logic [MAG_W-1:0]  den_src;
      logic [DUTY_W-1:0] quo_src;
      logic [NUM_W-1:0]  rem_in;
      logic [DUTY_W-1:0] quo_in;

      if (s == 0) begin : g_head
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_body
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      always_comb begin
         logic [NUM_W:0] trial;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int b = 0; b < DIV_STEP; b++) begin
            trial = {1'b0, rem_in}
                    - ((NUM_W+1)'(den_src) << (DUTY_W - 1 - s * DIV_STEP - b));
            if (!trial[NUM_W]) begin
               rem_in = trial[NUM_W-1:0];
               quo_in[DUTY_W - 1 - s * DIV_STEP - b] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            quo_ff[s] <= quo_in;
         end
      end

      if (s < DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[s]) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule
